// ===== hdl/thsd_pkg.sv =====
// shared types, constants and the crc-8 byte step for the thermometer scratchpad decoder
package thsd_pkg;

    localparam int ADDR_W     = 4;
    localparam int DIV_STEPS  = 15;
    localparam int DIV_CNT_W  = 4;
    localparam int QUO_W      = 15;
    localparam int FRAC_SHIFT = 7;
    localparam int CRC_BYTES  = 8;
    localparam int CRC_CNT_W  = 4;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_NINE_BIT_FAMILY = 2'd0;
    localparam logic [1:0] REG_ERROR_LIMIT     = 2'd1;
    localparam logic [1:0] REG_DISCONNECT_CODE = 2'd2;

    localparam logic [7:0]  RST_NINE_BIT_FAMILY = 8'd16;
    localparam logic [7:0]  RST_ERROR_LIMIT     = 8'd5;
    localparam logic [15:0] RST_DISCONNECT_CODE = 16'hE480;

    localparam logic [7:0] MODE_9BIT  = 8'h1F;
    localparam logic [7:0] MODE_10BIT = 8'h3F;
    localparam logic [7:0] MODE_11BIT = 8'h5F;
    localparam logic [7:0] MODE_12BIT = 8'h7F;

    localparam logic [3:0] RES_NONE = 4'd0;
    localparam logic [3:0] RES_9    = 4'd9;
    localparam logic [3:0] RES_10   = 4'd10;
    localparam logic [3:0] RES_11   = 4'd11;
    localparam logic [3:0] RES_12   = 4'd12;

    localparam logic [7:0]  CRC_POLY     = 8'h8C;
    localparam logic [7:0]  FAIL_MAX     = 8'hFF;
    localparam logic [15:0] NINE_BIT_OFS = 16'd16;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // dallas crc-8, lsb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ d[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/thsd_div.sv =====
// restoring divider, one quotient bit per cycle, for the fraction term
module thsd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [7:0]                dividend_mag,
    input  logic [7:0]                divisor,
    output logic                      busy,
    output logic [thsd_pkg::QUO_W-1:0] quotient
);

    logic [7:0]                        rem_reg;
    logic [7:0]                        rem_next;
    logic [thsd_pkg::QUO_W-1:0]        shq_reg;
    logic [thsd_pkg::QUO_W-1:0]        shq_next;
    logic [7:0]                        div_reg;
    logic [thsd_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [thsd_pkg::DIV_CNT_W-1:0]    cnt_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic [8:0]                        trial;
    logic [7:0]                        diff;
    logic                              ge;

    // partial remainder with the next dividend bit shifted in
    assign trial = {rem_reg, shq_reg[thsd_pkg::QUO_W-1]};
    // the difference is below the divisor whenever it is used
    assign diff  = trial[7:0] - div_reg;
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = 8'd0;
            shq_next  = {dividend_mag, {thsd_pkg::FRAC_SHIFT{1'b0}}};
            cnt_next  = thsd_pkg::DIV_CNT_W'(thsd_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : trial[7:0];
            shq_next = {shq_reg[thsd_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == thsd_pkg::DIV_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shq_reg <= shq_next;
        if (start)
            div_reg <= divisor;
    end

    assign busy     = busy_reg;
    assign quotient = shq_reg;

endmodule

// ===== hdl/thermometer_scratchpad_decoder_core.sv =====
// top level: scratchpad crc check, link tracking and temperature decode
//
// channel   dir  handshake                    payload
// s_*       in   s_tvalid / s_tready          s_tdata[79:0], s_tuser[0]
// m_*       out  m_tvalid / m_tready          m_tdata[31:0], m_tuser[1:0]
// apb       in   psel & penable & pwrite      paddr[3:0], pwdata[31:0], prdata[31:0]
//
// the block takes no new beat until it is back in idle. a beat passes through the
// accepting cycle, 15 steps of the bit-serial divider (the crc runs one byte per
// cycle alongside), the exit from the run state, and a finish cycle that writes the
// output register. the divider, not the crc, decides when the run state ends.
// a held result in the output register stalls only the finish cycle.
// reset clears the failure counter, the present flag and the registers to defaults.
module thermometer_scratchpad_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // family_code, temp_low_byte, temp_high_byte, alarm_high_byte, alarm_low_byte,
    // mode_byte, reserved_byte, remaining_count, count_per_degree, crc_byte
    input  logic [79:0]                 s_tdata,
    // read_ok
    input  logic [0:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // temperature[15:0], resolution_bits[19:16], error_run[27:20], zero fill
    output logic [31:0]                 m_tdata,
    // connected, good read (read_ok and crc match)
    output logic [1:0]                  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [thsd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    thsd_pkg::state_t state_reg;
    thsd_pkg::state_t state_next;

    logic [7:0]  nine_bit_family_reg;
    logic [7:0]  error_limit_reg;
    logic [15:0] disconnect_code_reg;

    logic [7:0]  fail_count_reg;
    logic        present_reg;

    logic [7:0]  family_reg;
    logic        read_ok_reg;
    logic [7:0]  low_reg;
    logic [7:0]  high_reg;
    logic [7:0]  mode_reg;
    logic [7:0]  crc_byte_reg;
    logic        neg_reg;
    logic        cpd_zero_reg;

    logic [63:0]                    crc_sh_reg;
    logic [7:0]                     crc_reg;
    logic [thsd_pkg::CRC_CNT_W-1:0] crc_cnt_reg;
    logic                           crc_done;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic        accept;
    logic        finish;
    logic        cfg_write;

    logic [8:0]  cnt_diff;
    logic [7:0]  cnt_mag;
    logic        div_busy;
    logic [thsd_pkg::QUO_W-1:0] quo;

    logic        good;
    logic [7:0]  fail_inc;
    logic [7:0]  fail_new;
    logic        conn;
    logic        nine_bit;
    logic [15:0] frac16;
    logic [15:0] t_plain;
    logic [15:0] t_nine;
    logic [15:0] temp_out;
    logic [3:0]  res_out;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == thsd_pkg::ST_IDLE);
    assign crc_done  = (crc_cnt_reg == thsd_pkg::CRC_CNT_W'(thsd_pkg::CRC_BYTES));
    assign finish    = (state_reg == thsd_pkg::ST_FIN) && (!m_tvalid_reg || m_tready);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // count_per_degree - remaining_count, split into sign and magnitude for the divider
    assign cnt_diff = {1'b0, s_tdata[71:64]} - {1'b0, s_tdata[63:56]};
    assign cnt_mag  = cnt_diff[8] ? 8'(9'd0 - cnt_diff) : cnt_diff[7:0];

    thsd_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .dividend_mag (cnt_mag),
        .divisor      (s_tdata[71:64]),
        .busy         (div_busy),
        .quotient     (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            thsd_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = thsd_pkg::ST_RUN;
            end
            thsd_pkg::ST_RUN:
            begin
                if (crc_done && !div_busy)
                    state_next = thsd_pkg::ST_FIN;
            end
            thsd_pkg::ST_FIN:
            begin
                if (finish)
                    state_next = thsd_pkg::ST_IDLE;
            end
            default:
                state_next = thsd_pkg::ST_IDLE;
        endcase
    end

    // link decision
    assign good     = read_ok_reg && (crc_reg == crc_byte_reg);
    assign fail_inc = (fail_count_reg == thsd_pkg::FAIL_MAX) ? thsd_pkg::FAIL_MAX
                                                              : fail_count_reg + 8'd1;
    assign fail_new = good ? 8'd0 : fail_inc;
    assign conn     = good || (present_reg && !(fail_inc > error_limit_reg));
    assign nine_bit = (family_reg == nine_bit_family_reg);

    // temperature decode
    assign frac16  = cpd_zero_reg ? 16'd0
                   : (neg_reg ? 16'd0 - {1'b0, quo} : {1'b0, quo});
    assign t_plain = {high_reg[4:0], low_reg, 3'b000};
    assign t_nine  = {high_reg[1:0], low_reg[7:1], 7'd0} - thsd_pkg::NINE_BIT_OFS + frac16;
    assign temp_out = !conn ? disconnect_code_reg : (nine_bit ? t_nine : t_plain);

    always_comb
    begin
        res_out = thsd_pkg::RES_NONE;
        if (nine_bit)
            res_out = thsd_pkg::RES_12;
        else if (conn)
        begin
            unique case (mode_reg)
                thsd_pkg::MODE_12BIT: res_out = thsd_pkg::RES_12;
                thsd_pkg::MODE_11BIT: res_out = thsd_pkg::RES_11;
                thsd_pkg::MODE_10BIT: res_out = thsd_pkg::RES_10;
                thsd_pkg::MODE_9BIT:  res_out = thsd_pkg::RES_9;
                default:              res_out = thsd_pkg::RES_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= thsd_pkg::ST_IDLE;
            nine_bit_family_reg <= thsd_pkg::RST_NINE_BIT_FAMILY;
            error_limit_reg     <= thsd_pkg::RST_ERROR_LIMIT;
            disconnect_code_reg <= thsd_pkg::RST_DISCONNECT_CODE;
            fail_count_reg      <= 8'd0;
            present_reg         <= 1'b0;
            crc_cnt_reg         <= '0;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    thsd_pkg::REG_NINE_BIT_FAMILY: nine_bit_family_reg <= pwdata[7:0];
                    thsd_pkg::REG_ERROR_LIMIT:     error_limit_reg     <= pwdata[7:0];
                    thsd_pkg::REG_DISCONNECT_CODE: disconnect_code_reg <= pwdata[15:0];
                    default:                       ;
                endcase
            end
            if (accept)
                crc_cnt_reg <= '0;
            else if ((state_reg == thsd_pkg::ST_RUN) && !crc_done)
                crc_cnt_reg <= crc_cnt_reg + 1'b1;
            if (finish)
            begin
                fail_count_reg <= fail_new;
                present_reg    <= conn;
                m_tvalid_reg   <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            family_reg   <= s_tdata[7:0];
            low_reg      <= s_tdata[15:8];
            high_reg     <= s_tdata[23:16];
            mode_reg     <= s_tdata[47:40];
            crc_byte_reg <= s_tdata[79:72];
            read_ok_reg  <= s_tuser[0];
            neg_reg      <= cnt_diff[8];
            cpd_zero_reg <= (s_tdata[71:64] == 8'd0);
            crc_sh_reg   <= s_tdata[71:8];
            crc_reg      <= 8'd0;
        end
        else if ((state_reg == thsd_pkg::ST_RUN) && !crc_done)
        begin
            crc_reg    <= thsd_pkg::crc8_byte(crc_reg, crc_sh_reg[7:0]);
            crc_sh_reg <= {8'd0, crc_sh_reg[63:8]};
        end
        if (finish)
        begin
            m_tdata_reg <= {4'd0, fail_new, res_out, temp_out};
            m_tuser_reg <= {good, conn};
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[3:2])
            thsd_pkg::REG_NINE_BIT_FAMILY: prdata = {24'd0, nine_bit_family_reg};
            thsd_pkg::REG_ERROR_LIMIT:     prdata = {24'd0, error_limit_reg};
            thsd_pkg::REG_DISCONNECT_CODE: prdata = {16'd0, disconnect_code_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/thsd_chk.sv =====
// port-level checker for the decoder core, bound to the top level
module thsd_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [31:0]                 m_tdata,
    input logic [1:0]                  m_tuser
);

    // a stalled result beat is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat dropped or changed while stalled");

    // the block works on one beat at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in work");

    // a good read always counts as connected and clears the failure run
    a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata[27:20] == 8'd0))
        else $error("good read not connected or failure run not cleared");

    // a failed read leaves a nonzero failure run
    a_fail_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[27:20] != 8'd0))
        else $error("failed read left a zero failure run");

endmodule

bind thermometer_scratchpad_decoder_core thsd_chk u_thsd_chk (.*);
